FILE: design/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// shared types and constants of the shannon-fano code builder
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int MaxSymbolsDef = 64;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_POP,
        ST_POPW,
        ST_LEAF,
        ST_LEAFW,
        ST_SPLIT_RD,
        ST_SPLIT_WAIT,
        ST_WALK_RD,
        ST_WALK_ACC,
        ST_PUSH_R,
        ST_PUSH_L,
        ST_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic store_entry;
        logic init;
        logic pop_addr;
        logic pop_take;
        logic leaf_rd;
        logic leaf_emit;
        logic split_rd;
        logic split_take;
        logic walk_rd;
        logic walk_acc;
        logic push_r;
        logic push_l;
        logic finish;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic empty_table;
        logic stack_empty;
        logic cur_single;
        logic cur_skip;
        logic walk_done;
    } t_status;

endpackage

FILE: design/shannon_fano_code_builder_unit.sv
// ----------------------------------------------------------------------------
// shannon_fano_code_builder_unit
// builds shannon-fano codes for a table of up to MaxSymbols entries
// ----------------------------------------------------------------------------
// entries load one word a cycle while busy is low; the word with last set
// starts the build. the build walks each range with a two-pointer split over
// the single weight ram port, with a read and an accumulate state per walk
// step, pop and push states per range and read and emit states per leaf;
// total work grows with the square of the table size in the worst case.
// each code word is shown for one cycle on o_valid and cannot be stalled.
module shannon_fano_code_builder_unit #(
    parameter int MaxSymbols = sfc_pkg::MaxSymbolsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_symbol,
    input  logic [31:0] i_weight,
    input  logic [31:0] i_occurrences,
    input  logic        i_last,
    output logic        o_valid,
    output logic [7:0]  o_out_symbol,
    output logic [5:0]  o_code_length,
    output logic [62:0] o_code_bits,
    output logic [63:0] o_total_bits,
    output logic        o_last_code
);
    import sfc_pkg::*;

    t_cmd    cmd;
    t_status status;

    sfc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_last(i_last),
        .i_status(status), .o_cmd(cmd), .o_busy(busy)
    );

    sfc_datapath #(.MaxSymbols(MaxSymbols)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_symbol(i_symbol), .i_weight(i_weight), .i_occurrences(i_occurrences),
        .o_status(status), .o_valid(o_valid), .o_out_symbol(o_out_symbol),
        .o_code_length(o_code_length), .o_code_bits(o_code_bits),
        .o_total_bits(o_total_bits), .o_last_code(o_last_code)
    );
endmodule

FILE: design/sfc_ram.sv
// ----------------------------------------------------------------------------
// sfc_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module sfc_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/sfc_ctrl.sv
// ----------------------------------------------------------------------------
// sfc_ctrl
// controller state machine of the code builder
// ----------------------------------------------------------------------------
module sfc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_last,
    input  sfc_pkg::t_status i_status,
    output sfc_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import sfc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (i_start && i_last) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                n_state = i_status.empty_table ? ST_DONE : ST_POP;
            end
            ST_POP: begin
                n_state = i_status.stack_empty ? ST_DONE : ST_POPW;
            end
            ST_POPW: begin
                if (i_status.cur_skip) begin
                    n_state = ST_POP;
                end else if (i_status.cur_single) begin
                    n_state = ST_LEAF;
                end else begin
                    n_state = ST_SPLIT_RD;
                end
            end
            ST_LEAF:       n_state = ST_LEAFW;
            ST_LEAFW:      n_state = ST_POP;
            ST_SPLIT_RD:   n_state = ST_SPLIT_WAIT;
            ST_SPLIT_WAIT: n_state = i_status.walk_done ? ST_PUSH_R : ST_WALK_RD;
            ST_WALK_RD:    n_state = ST_WALK_ACC;
            ST_WALK_ACC:   n_state = i_status.walk_done ? ST_PUSH_R : ST_WALK_RD;
            ST_PUSH_R:     n_state = ST_PUSH_L;
            ST_PUSH_L:     n_state = ST_POP;
            ST_DONE:       n_state = ST_LOAD;
            default:       n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_LOAD: begin
                o_busy = 1'b0;
                o_cmd.store_entry = i_start;
            end
            ST_INIT:       o_cmd.init = 1'b1;
            ST_POP:        o_cmd.pop_addr = 1'b1;
            ST_POPW:       o_cmd.pop_take = 1'b1;
            ST_LEAF:       o_cmd.leaf_rd = 1'b1;
            ST_LEAFW:      o_cmd.leaf_emit = 1'b1;
            ST_SPLIT_RD:   o_cmd.split_rd = 1'b1;
            ST_SPLIT_WAIT: o_cmd.split_take = 1'b1;
            ST_WALK_RD:    o_cmd.walk_rd = 1'b1;
            ST_WALK_ACC:   o_cmd.walk_acc = 1'b1;
            ST_PUSH_R:     o_cmd.push_r = 1'b1;
            ST_PUSH_L:     o_cmd.push_l = 1'b1;
            ST_DONE:       o_cmd.finish = 1'b1;
            default:       o_cmd = '0;
        endcase
    end
endmodule

FILE: design/sfc_datapath.sv
// ----------------------------------------------------------------------------
// sfc_datapath
// entry stores, range stack, split walk and result registers
// ----------------------------------------------------------------------------
module sfc_datapath #(
    parameter int MaxSymbols = sfc_pkg::MaxSymbolsDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfc_pkg::t_cmd    i_cmd,
    input  logic [7:0]       i_symbol,
    input  logic [31:0]      i_weight,
    input  logic [31:0]      i_occurrences,
    output sfc_pkg::t_status o_status,
    output logic             o_valid,
    output logic [7:0]       o_out_symbol,
    output logic [5:0]       o_code_length,
    output logic [62:0]      o_code_bits,
    output logic [63:0]      o_total_bits,
    output logic             o_last_code
);
    import sfc_pkg::*;

    localparam int AW = $clog2(MaxSymbols);
    localparam int CW = $clog2(MaxSymbols + 1);
    localparam int SD = 1 << CW;
    localparam int SW = AW + CW + 6 + 63;

    logic [CW-1:0] r_loaded;
    logic [CW-1:0] r_sp;
    logic [63:0]   r_total;
    logic [AW-1:0] r_lo, r_li, r_ri;
    logic [CW-1:0] r_cnt;
    logic [5:0]    r_depth;
    logic [62:0]   r_code;
    logic [39:0]   r_ls, r_rs;
    logic          r_side;  // 1 when the walk extended the right side
    logic          r_rs_pend;
    logic          r_valid;
    logic [7:0]    r_osym;
    logic [5:0]    r_olen;
    logic [62:0]   r_obits;
    logic [63:0]   r_ototal;
    logic          r_olast;

    // weight ram: one port, address mux
    logic [AW-1:0] w_addr, e_addr;
    logic          w_we;
    logic [31:0]   w_rd, s_cnt_rd;
    logic [7:0]    s_sym_rd;
    logic [SW-1:0] stk_rd, stk_wd;
    logic [CW-1:0] stk_addr;
    logic          stk_we;

    logic [AW:0]  hi_ext;
    logic [AW-1:0] hi_idx;
    logic [39:0]   rs_now;
    logic          ls_ge;

    assign hi_ext = {1'b0, r_lo} + (AW+1)'(r_cnt) - (AW+1)'(1);
    assign hi_idx = hi_ext[AW-1:0];
    // right end weight is still on the ram output in the first walk step
    assign rs_now = r_rs_pend ? 40'(w_rd) : r_rs;
    assign ls_ge  = r_ls >= rs_now;
    assign w_we   = i_cmd.store_entry && (r_loaded < CW'(MaxSymbols));

    always_comb begin
        w_addr = r_loaded[AW-1:0];
        e_addr = r_loaded[AW-1:0];
        if (i_cmd.split_rd) begin
            w_addr = r_lo;
        end else if (i_cmd.split_take) begin
            w_addr = hi_idx;
        end else if (i_cmd.walk_rd) begin
            w_addr = ls_ge ? (r_ri - AW'(1)) : (r_li + AW'(1));
        end
        if (i_cmd.leaf_rd) begin
            e_addr = r_lo;
        end
    end

    sfc_ram #(.Width(32), .Depth(MaxSymbols)) u_weight (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(i_weight), .o_rdata(w_rd)
    );
    sfc_ram #(.Width(8), .Depth(MaxSymbols)) u_symbol (
        .i_clk(i_clk), .i_we(w_we), .i_addr(e_addr),
        .i_wdata(i_symbol), .o_rdata(s_sym_rd)
    );
    sfc_ram #(.Width(32), .Depth(MaxSymbols)) u_count (
        .i_clk(i_clk), .i_we(w_we), .i_addr(e_addr),
        .i_wdata(i_occurrences), .o_rdata(s_cnt_rd)
    );

    // range stack entry: lo, cnt, depth, code
    always_comb begin
        stk_we   = 1'b0;
        stk_addr = r_sp - CW'(1);
        stk_wd   = {r_lo, r_cnt, r_depth, r_code};
        if (i_cmd.init) begin
            stk_we   = 1'b1;
            stk_addr = '0;
            stk_wd   = {AW'(0), r_loaded, 6'd0, 63'd0};
        end else if (i_cmd.push_r) begin
            stk_we   = 1'b1;
            stk_addr = r_sp;
            stk_wd   = {r_ri, CW'(hi_ext - {1'b0, r_ri} + (AW+1)'(1)),
                        r_depth + 6'd1, {r_code[61:0], 1'b1}};
        end else if (i_cmd.push_l) begin
            stk_we   = 1'b1;
            stk_addr = r_sp;
            stk_wd   = {r_lo, CW'(r_ri - r_lo), r_depth + 6'd1, {r_code[61:0], 1'b0}};
        end
    end

    sfc_ram #(.Width(SW), .Depth(SD)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_addr(stk_addr),
        .i_wdata(stk_wd), .o_rdata(stk_rd)
    );

    // leaf product, one 32x6 multiply
    logic [63:0] add;
    logic [64:0] sum;
    assign add = 64'(s_cnt_rd) * 64'(r_depth);
    assign sum = {1'b0, r_total} + {1'b0, add};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded  <= '0;
            r_sp      <= '0;
            r_total   <= '0;
            r_valid   <= 1'b0;
            r_rs_pend <= 1'b0;
        end else begin
            r_valid   <= 1'b0;
            r_rs_pend <= i_cmd.split_take;
            if (w_we) begin
                r_loaded <= r_loaded + CW'(1);
            end
            if (i_cmd.init) begin
                r_sp    <= CW'(1);
                r_total <= '0;
            end
            if (i_cmd.pop_addr && r_sp != '0) begin
                r_sp <= r_sp - CW'(1);
            end
            if (i_cmd.push_r || i_cmd.push_l) begin
                r_sp <= r_sp + CW'(1);
            end
            if (i_cmd.leaf_emit) begin
                r_total <= sum[64] ? '1 : sum[63:0];
                r_valid <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_loaded <= '0;
                r_sp     <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_take) begin
            {r_lo, r_cnt, r_depth, r_code} <= stk_rd;
        end
        if (i_cmd.split_rd) begin
            r_li <= r_lo;
            r_ri <= hi_idx;
        end
        if (i_cmd.split_take) begin
            r_ls <= 40'(w_rd);
        end
        // right sum arrives in the cycle after the left one
        if (r_rs_pend) begin
            r_rs <= 40'(w_rd);
        end
        if (i_cmd.walk_rd) begin
            r_side <= ls_ge;
            if (ls_ge) begin
                r_ri <= r_ri - AW'(1);
            end else begin
                r_li <= r_li + AW'(1);
            end
        end
        if (i_cmd.walk_acc) begin
            if (r_side) begin
                r_rs <= r_rs + 40'(w_rd);
            end else begin
                r_ls <= r_ls + 40'(w_rd);
            end
        end
        if (i_cmd.leaf_emit) begin
            r_osym   <= s_sym_rd;
            r_olen   <= r_depth;
            r_obits  <= r_code;
            r_ototal <= sum[64] ? '1 : sum[63:0];
            r_olast  <= (r_sp == '0);
        end
    end

    assign o_status.empty_table = (r_loaded == '0);
    assign o_status.stack_empty = (r_sp == '0);
    assign o_status.cur_single  = (stk_rd[69 +: CW] == CW'(1));
    assign o_status.cur_skip    = (stk_rd[69 +: CW] == '0);
    assign o_status.walk_done   = ({1'b0, r_li} + (AW+1)'(1)) >= {1'b0, r_ri};

    assign o_valid       = r_valid;
    assign o_out_symbol  = r_osym;
    assign o_code_length = r_olen;
    assign o_code_bits   = r_obits;
    assign o_total_bits  = r_ototal;
    assign o_last_code   = r_olast;
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the shannon-fano code builder word by word against a predictor
// that splits each table with the same two-pointer walk and range stack.
// short directed tables and one overfull table come first, then random tables, with random gaps in two of three phases.
// ----------------------------------------------------------------------------
class code_scoreboard;

    typedef struct {
        logic [7:0]  sym;
        logic [5:0]  len;
        logic [62:0] bits;
        logic [63:0] total;
        logic        last;
    } t_code;

    localparam int Cap = sfc_pkg::MaxSymbolsDef;

    logic [7:0]  sym_tab [Cap];
    logic [31:0] wgt_tab [Cap];
    logic [31:0] occ_tab [Cap];
    int          n_held;
    t_code       code_q [$];
    int          errors;

    function new();
        n_held = 0;
        errors = 0;
    endfunction

    function int pending();
        return code_q.size();
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // splits the held table and queues one code per entry, left first
    function void build_codes();
        int          r_lo [Cap + 1];
        int          r_cnt [Cap + 1];
        int          r_dep [Cap + 1];
        logic [62:0] r_code [Cap + 1];
        int          sp, lo, cnt, dep, li, ri;
        logic [62:0] code;
        logic [63:0] ls, rs, add, total;
        t_code       c;
        sp = 1;
        r_lo[0] = 0;
        r_cnt[0] = n_held;
        r_dep[0] = 0;
        r_code[0] = '0;
        total = '0;
        while (sp > 0) begin
            sp--;
            lo = r_lo[sp];
            cnt = r_cnt[sp];
            dep = r_dep[sp];
            code = r_code[sp];
            if (cnt == 1) begin
                add = 64'(dep) * 64'(occ_tab[lo]);
                total = (total > ~add) ? '1 : total + add;
                c.sym = sym_tab[lo];
                c.len = 6'(dep);
                c.bits = code;
                c.total = total;
                c.last = 1'b0;
                code_q.push_back(c);
            end else if (cnt > 1) begin
                li = lo;
                ri = lo + cnt - 1;
                ls = 64'(wgt_tab[li]);
                rs = 64'(wgt_tab[ri]);
                while (li + 1 < ri) begin
                    // tie goes to the right side
                    if (ls >= rs) begin
                        ri--;
                        rs += 64'(wgt_tab[ri]);
                    end else begin
                        li++;
                        ls += 64'(wgt_tab[li]);
                    end
                end
                r_lo[sp] = ri;
                r_cnt[sp] = lo + cnt - ri;
                r_dep[sp] = dep + 1;
                r_code[sp] = {code[61:0], 1'b1};
                sp++;
                r_lo[sp] = lo;
                r_cnt[sp] = ri - lo;
                r_dep[sp] = dep + 1;
                r_code[sp] = {code[61:0], 1'b0};
                sp++;
            end
        end
        code_q[code_q.size() - 1].last = 1'b1;
        n_held = 0;
    endfunction

    function void note_entry(logic [7:0] sym, logic [31:0] wgt, logic [31:0] occ,
                             logic last);
        // a full table drops the word
        if (n_held < Cap) begin
            sym_tab[n_held] = sym;
            wgt_tab[n_held] = wgt;
            occ_tab[n_held] = occ;
            n_held++;
        end
        if (last) build_codes();
    endfunction

    task check_code(logic [7:0] sym, logic [5:0] len, logic [62:0] bits,
                    logic [63:0] total, logic last);
        t_code c;
        if (code_q.size() == 0) begin
            report($sformatf("unexpected code for symbol %0d", sym));
        end else begin
            c = code_q.pop_front();
            if (sym !== c.sym)
                report($sformatf("symbol %0d, want %0d", sym, c.sym));
            if (len !== c.len)
                report($sformatf("sym %0d length %0d, want %0d", c.sym, len, c.len));
            if (bits !== c.bits)
                report($sformatf("sym %0d bits %h, want %h", c.sym, bits, c.bits));
            if (total !== c.total)
                report($sformatf("sym %0d total %0d, want %0d", c.sym, total, c.total));
            if (last !== c.last)
                report($sformatf("sym %0d last %b, want %b", c.sym, last, c.last));
        end
    endtask

endclass

module testbench;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  i_symbol;
    logic [31:0] i_weight;
    logic [31:0] i_occurrences;
    logic        i_last;
    logic        o_valid;
    logic [7:0]  o_out_symbol;
    logic [5:0]  o_code_length;
    logic [62:0] o_code_bits;
    logic [63:0] o_total_bits;
    logic        o_last_code;

    code_scoreboard sb = new();
    int             idle_pct;
    int             n_sent;
    longint         cycles;

    shannon_fano_code_builder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_symbol      (i_symbol),
        .i_weight      (i_weight),
        .i_occurrences (i_occurrences),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .o_out_symbol  (o_out_symbol),
        .o_code_length (o_code_length),
        .o_code_bits   (o_code_bits),
        .o_total_bits  (o_total_bits),
        .o_last_code   (o_last_code)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_code(o_out_symbol, o_code_length, o_code_bits, o_total_bits,
                          o_last_code);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task send_word(logic [7:0] sym, logic [31:0] wgt, logic [31:0] occ, logic last);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_symbol <= sym;
        i_weight <= wgt;
        i_occurrences <= occ;
        i_last <= last;
        do @(posedge i_clk); while (busy);
        sb.note_entry(sym, wgt, occ, last);
        n_sent++;
    endtask

    function logic [31:0] pick_weight();
        case ($urandom_range(3))
            0: return 32'($urandom_range(0, 15));
            1: return $urandom;
            2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: return 32'($urandom_range(0, 1000));
        endcase
    endfunction

    task send_table(int n, bit rand_vals);
        for (int k = 0; k < n; k++)
            send_word(8'($urandom), rand_vals ? pick_weight() : 32'd7,
                      rand_vals ? pick_weight() : 32'hFFFF_FFFF, k == n - 1);
    endtask

    task drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    initial begin
        cycles = 0;
        n_sent = 0;
        idle_pct = 36;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_symbol <= '0;
        i_weight <= '0;
        i_occurrences <= '0;
        i_last <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single entry, zero length and zero total
        send_word(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // two zero weights
        send_word(8'h00, 32'h0, 32'h0, 1'b0);
        send_word(8'h01, 32'h0, 32'hFFFF_FFFF, 1'b1);
        // equal weights exercise the tie rule
        send_table(4, 1'b0);
        // extreme weights
        send_word(8'hA5, 32'hFFFF_FFFF, 32'd1, 1'b0);
        send_word(8'h5A, 32'h0, 32'd2, 1'b0);
        send_word(8'h3C, 32'hFFFF_FFFF, 32'd3, 1'b0);
        send_word(8'hC3, 32'h1, 32'hFFFF_FFFF, 1'b1);
        drain();
        // full table, then overflow words dropped, last among them
        send_table(67, 1'b1);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 36 : (ph == 1) ? 66 : 0;
            while (n_sent < 150 + ph * 150) begin
                case ($urandom_range(19))
                    0: send_table($urandom_range(1) ? 64 : 66, 1'b1);
                    1, 2: send_table($urandom_range(9, 24), 1'b1);
                    default: send_table($urandom_range(1, 8), 1'b1);
                endcase
                if ($urandom_range(5) == 0) drain();
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/sfc_pkg.sv
design/sfc_ram.sv
design/sfc_ctrl.sv
design/sfc_datapath.sv
design/shannon_fano_code_builder_unit.sv
bench/testbench.sv
